// ===== rtl/core/ucw_pkg.sv =====
// Shared types, constants and the screen width table for the UTF-8 column
// width measure. No dependencies; the decoder, measure stage, top level and testbench import this package.
package ucw_pkg;

    localparam int CP_W     = 21;
    localparam int FIELD_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 2'd1;

    localparam logic [FIELD_W-1:0] COLUMN_LIMIT_RESET = 16'hFFFF;
    localparam logic [FIELD_W-1:0] BASE_OFFSET_RESET  = 16'h0000;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SO       = 21'h00000E;
    localparam logic [CP_W-1:0] CP_SI       = 21'h00000F;

    localparam int NUM_RANGES = 37;

    localparam logic [CP_W-1:0] RANGE_TOP [NUM_RANGES] = '{
        21'd126,    21'd159,    21'd687,    21'd710,    21'd711,    21'd727,
        21'd733,    21'd879,    21'd1154,   21'd1161,   21'd4347,   21'd4447,
        21'd7467,   21'd7521,   21'd8369,   21'd8426,   21'd9000,   21'd9002,
        21'd11021,  21'd12350,  21'd12351,  21'd12438,  21'd12442,  21'd19893,
        21'd19967,  21'd55203,  21'd63743,  21'd64106,  21'd65039,  21'd65059,
        21'd65131,  21'd65279,  21'd65376,  21'd65500,  21'd120831, 21'd262141,
        21'd1114109
    };

    localparam logic [1:0] RANGE_COLS [NUM_RANGES] = '{
        2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2,
        2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2,
        2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1,
        2'd2, 2'd1, 2'd1, 2'd2, 2'd1
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_payload_t;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [1:0]         char_width;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] columns_before;
        logic [FIELD_W-1:0] columns_after;
        logic               fits;
        logic               replaced;
        logic               text_done;
    } out_payload_t;

    // Decoder to measure stage: one finished character
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            done;
    } dec_t;

    // First matching range wins; shift-out and shift-in are zero width
    function automatic logic [1:0] cols_of(input logic [CP_W-1:0] cp);
        logic [1:0] w;
        w = 2'd1;
        for (int k = NUM_RANGES - 1; k >= 0; k--) begin
            if (cp <= RANGE_TOP[k]) begin
                w = RANGE_COLS[k];
            end
        end
        if (cp == CP_SO || cp == CP_SI) begin
            w = 2'd0;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/ucw_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload type comes from ucw_pkg at the instantiation site.
interface ucw_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ucw_decoder.sv =====
// UTF-8 sequence decoder: holds the partial sequence and byte position,
// and flags a finished character when a sequence completes or the text ends. Uses ucw_pkg.
module ucw_decoder
    import ucw_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_text,
    output dec_t                   dec,
    output logic [OFFSET_BITS-1:0] char_pos
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [1:0]             pending_reg, pending_next;
    logic [7:0]             lead_reg, lead_next;
    logic [CP_W-1:0]        gathered_reg, gathered_next;
    logic                   invalid_reg, invalid_next;
    logic [OFFSET_BITS-1:0] counter_reg, counter_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [1:0]             need_new;
    logic [1:0]             need_held;
    logic [1:0]             pending_dec;

    function automatic logic [1:0] tail_len(input logic [7:0] lead);
        logic [1:0] n;
        if (!lead[7]) begin
            n = 2'd0;
        end
        else if ((lead & 8'h60) == 8'h40) begin
            n = 2'd1;
        end
        else if ((lead & 8'h70) == 8'h60) begin
            n = 2'd2;
        end
        else begin
            n = 2'd3;
        end
        return n;
    endfunction

    always_comb begin
        need_new      = tail_len(data_byte);
        need_held     = tail_len(lead_reg);
        pending_dec   = pending_reg - 2'd1;
        pending_next  = pending_reg;
        lead_next     = lead_reg;
        gathered_next = gathered_reg;
        invalid_next  = invalid_reg;
        start_next    = start_reg;
        counter_next  = (counter_reg != OFF_MAX) ? counter_reg + 1'b1 : counter_reg;
        dec.emit       = 1'b0;
        dec.code_point = REPLACEMENT;
        dec.replaced   = 1'b1;
        dec.done       = end_of_text;

        if (pending_reg == 2'd0) begin
            start_next   = counter_reg;
            lead_next    = data_byte;
            invalid_next = 1'b0;
            pending_next = need_new;
            case (need_new)
                2'd0:
                begin
                    dec.emit       = 1'b1;
                    dec.code_point = CP_W'(data_byte);
                    dec.replaced   = 1'b0;
                end
                2'd1:
                begin
                    gathered_next = CP_W'(data_byte[4:0]);
                    dec.emit      = end_of_text;
                end
                2'd2:
                begin
                    gathered_next = CP_W'(data_byte[3:0]);
                    dec.emit      = end_of_text;
                end
                default:
                begin
                    if ((data_byte & 8'h78) == 8'h70) begin
                        gathered_next = CP_W'(data_byte[2:0]);
                    end
                    else begin
                        gathered_next = '0;
                        invalid_next  = 1'b1;
                    end
                    dec.emit = end_of_text;
                end
            endcase
        end
        else begin
            // surrogate check applies to the first continuation after ED only
            invalid_next = invalid_reg
                         || (data_byte[7:6] != 2'b10)
                         || (pending_reg == need_held && need_held == 2'd2
                             && lead_reg[3:0] == 4'hD && data_byte[5]);
            gathered_next = {gathered_reg[CP_W-7:0], data_byte[5:0]};
            pending_next  = pending_dec;
            if (pending_dec == 2'd0) begin
                dec.emit       = 1'b1;
                dec.replaced   = invalid_next;
                dec.code_point = invalid_next ? REPLACEMENT : gathered_next;
            end
            else begin
                dec.emit = end_of_text;
            end
        end

        char_pos = start_next;

        if (end_of_text) begin
            pending_next  = '0;
            lead_next     = '0;
            gathered_next = '0;
            invalid_next  = 1'b0;
            counter_next  = '0;
            start_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pending_reg  <= '0;
            lead_reg     <= '0;
            gathered_reg <= '0;
            invalid_reg  <= 1'b0;
            counter_reg  <= '0;
            start_reg    <= '0;
        end
        else if (step) begin
            pending_reg  <= pending_next;
            lead_reg     <= lead_next;
            gathered_reg <= gathered_next;
            invalid_reg  <= invalid_next;
            counter_reg  <= counter_next;
            start_reg    <= start_next;
        end
    end

endmodule

// ===== rtl/core/ucw_measure.sv =====
// Column accounting: width lookup, running fitted total with overflow
// freeze, and saturated absolute start offset. Uses ucw_pkg.
module ucw_measure
    import ucw_pkg::*;
#(
    parameter int OFFSET_BITS = 16,
    parameter int COLUMN_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  dec_t                   dec,
    input  logic [OFFSET_BITS-1:0] char_pos,
    input  logic [FIELD_W-1:0]     column_limit,
    input  logic [FIELD_W-1:0]     base_offset,
    output out_payload_t           result
);

    localparam int SUM_W = (COLUMN_BITS + 1 > FIELD_W) ? COLUMN_BITS + 1 : FIELD_W;
    localparam int OFS_W = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [COLUMN_BITS-1:0] total_reg, total_next;
    logic                   over_reg, over_next;
    logic [1:0]             width;
    logic [SUM_W-1:0]       sum;
    logic                   fit;
    logic [COLUMN_BITS-1:0] after;
    logic [OFS_W-1:0]       start_sum;
    logic [OFFSET_BITS-1:0] start_sat;

    always_comb begin
        width     = cols_of(dec.code_point);
        sum       = SUM_W'(total_reg) + SUM_W'(width);
        fit       = !over_reg && (sum <= SUM_W'(column_limit));
        after     = total_reg;
        if (fit) begin
            after = (sum > SUM_W'(COL_MAX)) ? COL_MAX : sum[COLUMN_BITS-1:0];
        end
        start_sum = OFS_W'(base_offset) + OFS_W'(char_pos);
        start_sat = (start_sum > OFS_W'(OFF_MAX)) ? OFF_MAX : start_sum[OFFSET_BITS-1:0];

        result.code_point     = dec.code_point;
        result.char_width     = width;
        result.start_offset   = FIELD_W'(start_sat);
        result.columns_before = FIELD_W'(total_reg);
        result.columns_after  = FIELD_W'(after);
        result.fits           = fit;
        result.replaced       = dec.replaced;
        result.text_done      = dec.done;

        total_next = total_reg;
        over_next  = over_reg;
        if (dec.done) begin
            total_next = '0;
            over_next  = 1'b0;
        end
        else if (dec.emit) begin
            total_next = after;
            over_next  = over_reg || !fit;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg <= '0;
            over_reg  <= 1'b0;
        end
        else if (step) begin
            total_reg <= total_next;
            over_reg  <= over_next;
        end
    end

endmodule

// ===== rtl/core/utf8_column_width_measure.sv =====
// Top level of the UTF-8 column width measure: input register, decoder,
// measure stage, result register and config registers. Uses ucw_pkg.
//
//  channel      dir  handshake      payload
//  byte_stream  in   valid/ready    data_byte, end_of_text
//  char_stream  out  valid/ready    code_point .. text_done (one per character)
//  cfg          in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One byte per cycle sustained while char_stream takes its characters; a byte passes
// through the input register and then the result register on its way to char_stream.
// The decoder and column logic between them is one combinational step.
// Bytes that end no character advance even while the result register stalls.
// Reset clears all decoder and column state and loads the register defaults.
module utf8_column_width_measure
    import ucw_pkg::*;
#(
    parameter int OFFSET_BITS = 16,
    parameter int COLUMN_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FIELD_W-1:0]    cfg_data,
    ucw_stream_if.sink            byte_stream,
    ucw_stream_if.source          char_stream
);

    logic [FIELD_W-1:0]     column_limit_reg;
    logic [FIELD_W-1:0]     base_offset_reg;
    logic                   in_valid_reg, in_valid_next;
    in_payload_t            in_data_reg;
    logic                   out_valid_reg, out_valid_next;
    out_payload_t           out_data_reg;
    logic                   advance;
    dec_t                   dec;
    logic [OFFSET_BITS-1:0] char_pos;
    out_payload_t           result;

    ucw_decoder #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (in_data_reg.data_byte),
        .end_of_text (in_data_reg.end_of_text),
        .dec         (dec),
        .char_pos    (char_pos)
    );

    ucw_measure #(
        .OFFSET_BITS (OFFSET_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_measure (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .dec          (dec),
        .char_pos     (char_pos),
        .column_limit (column_limit_reg),
        .base_offset  (base_offset_reg),
        .result       (result)
    );

    always_comb begin
        advance = in_valid_reg && (!dec.emit || !out_valid_reg || char_stream.ready);
        byte_stream.ready = !in_valid_reg || advance;

        in_valid_next = in_valid_reg;
        if (byte_stream.valid && byte_stream.ready) begin
            in_valid_next = 1'b1;
        end
        else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && dec.emit) begin
            out_valid_next = 1'b1;
        end
        else if (char_stream.ready) begin
            out_valid_next = 1'b0;
        end

        char_stream.valid   = out_valid_reg;
        char_stream.payload = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            column_limit_reg <= COLUMN_LIMIT_RESET;
            base_offset_reg  <= BASE_OFFSET_RESET;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_COLUMN_LIMIT: column_limit_reg <= cfg_data;
                    REG_BASE_OFFSET:  base_offset_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk) begin
        if (byte_stream.valid && byte_stream.ready) begin
            in_data_reg <= byte_stream.payload;
        end
        if (advance && dec.emit) begin
            out_data_reg <= result;
        end
    end

    // a held byte is never dropped or overwritten before it advances
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a byte");

    // a character that does not fit leaves the column total unchanged
    a_nofit_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.fits
            |-> out_data_reg.columns_after == out_data_reg.columns_before)
        else $error("column total moved on a character that does not fit");

    // a replaced character always carries the replacement code point
    a_replaced_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.replaced |-> out_data_reg.code_point == REPLACEMENT)
        else $error("replaced character without replacement code point");

endmodule

// ===== tb/utf8_column_width_measure_test.sv =====
// Self-checking testbench for utf8_column_width_measure: a directed table, then
// random UTF-8 text under several register settings.
// Depends on ucw_pkg, ucw_stream_if and the RTL top level.
module utf8_column_width_measure_test
    import ucw_pkg::*;
();

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_CAP    = 40;
    localparam int PHASE_ITEMS   = 88;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int unsigned BAND_END [NUM_RANGES] = '{
        126, 159, 687, 710, 711, 727, 733, 879, 1154, 1161, 4347, 4447,
        7467, 7521, 8369, 8426, 9000, 9002, 11021, 12350, 12351, 12438,
        12442, 19893, 19967, 55203, 63743, 64106, 65039, 65059, 65131, 65279,
        65376, 65500, 120831, 262141, 1114109
    };
    localparam logic [1:0] BAND_COLS [NUM_RANGES] = '{
        2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2,
        2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2,
        2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1,
        2'd2, 2'd1, 2'd1, 2'd2, 2'd1
    };

    localparam out_payload_t UNTYPED = '0;

    typedef struct {
        logic [7:0]   data_byte;
        logic         end_of_text;
        bit           typed;
        out_payload_t want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    ucw_stream_if #(.payload_t(in_payload_t))  byte_stream ();
    ucw_stream_if #(.payload_t(out_payload_t)) char_stream ();

    utf8_column_width_measure dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_stream (byte_stream),
        .char_stream (char_stream)
    );

    // Decoder and column state of the predictor
    logic [FIELD_W-1:0] limit_q;
    logic [FIELD_W-1:0] base_q;
    logic [1:0]         tail_left;
    logic [7:0]         lead_q;
    logic [CP_W-1:0]    bits_q;
    logic               bad_q;
    logic [FIELD_W-1:0] byte_count;
    logic [FIELD_W-1:0] lead_start;
    logic [FIELD_W-1:0] column_sum;
    logic               overflow_q;

    out_payload_t expected_chars [$];
    out_payload_t oldest;
    script_row_t  script [24];
    int           fail_count  = 0;
    int           cycle_count = 0;
    int           ready_run   = 0;
    bit           pacing      = 1'b1;

    always #1 clk = ~clk;

    function automatic logic [1:0] screen_cols(input logic [CP_W-1:0] cp);
        if (cp == CP_SO || cp == CP_SI)
        begin
            return 2'd0;
        end
        for (int k = 0; k < NUM_RANGES; k++)
        begin
            if (cp <= BAND_END[k])
            begin
                return BAND_COLS[k];
            end
        end
        return 2'd1;
    endfunction

    function automatic logic [1:0] tail_of(input logic [7:0] b);
        if (!b[7])
        begin
            return 2'd0;
        end
        if (b[6:5] == 2'b10)
        begin
            return 2'd1;
        end
        if (b[6:4] == 3'b110)
        begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

    // Mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic clear_text();
        tail_left  = 2'd0;
        lead_q     = 8'd0;
        bits_q     = '0;
        bad_q      = 1'b0;
        byte_count = '0;
        lead_start = '0;
        column_sum = '0;
        overflow_q = 1'b0;
    endtask

    task automatic finish_char(input logic [CP_W-1:0] cp, input logic bad, input logic done);
        logic [1:0]         w;
        logic [FIELD_W:0]   start;
        logic [FIELD_W:0]   sum;
        out_payload_t       r;
        w     = screen_cols(cp);
        start = {1'b0, base_q} + {1'b0, lead_start};
        sum   = {1'b0, column_sum} + {15'd0, w};
        r.code_point     = cp;
        r.char_width     = w;
        r.start_offset   = start[FIELD_W] ? '1 : start[FIELD_W-1:0];
        r.columns_before = column_sum;
        r.replaced       = bad;
        r.text_done      = done;
        if (!overflow_q && sum <= {1'b0, limit_q})
        begin
            r.fits     = 1'b1;
            column_sum = sum[FIELD_W] ? '1 : sum[FIELD_W-1:0];
        end
        else
        begin
            r.fits     = 1'b0;
            overflow_q = 1'b1;
        end
        r.columns_after = column_sum;
        expected_chars.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [FIELD_W-1:0] pos;
        logic [1:0]         need;
        pos = byte_count;
        if (byte_count != '1)
        begin
            byte_count = byte_count + 1'b1;
        end
        if (tail_left == 2'd0)
        begin
            need       = tail_of(b);
            lead_start = pos;
            lead_q     = b;
            bad_q      = 1'b0;
            if (need == 2'd0)
            begin
                finish_char({13'd0, b}, 1'b0, eot);
            end
            else
            begin
                if (need == 2'd1)
                begin
                    bits_q = {16'd0, b[4:0]};
                end
                else if (need == 2'd2)
                begin
                    bits_q = {17'd0, b[3:0]};
                end
                else if (b[6:3] == 4'b1110)
                begin
                    bits_q = {18'd0, b[2:0]};
                end
                else
                begin
                    bits_q = '0;
                    bad_q  = 1'b1;
                end
                tail_left = need;
                if (eot)
                begin
                    finish_char(REPLACEMENT, 1'b1, 1'b1);
                end
            end
        end
        else
        begin
            need = tail_of(lead_q);
            if (b[7:6] != 2'b10)
            begin
                bad_q = 1'b1;
            end
            // surrogate half after ED
            if (tail_left == need && need == 2'd2 && lead_q[3:0] == 4'hD && b[5])
            begin
                bad_q = 1'b1;
            end
            bits_q    = {bits_q[14:0], b[5:0]};
            tail_left = tail_left - 1'b1;
            if (tail_left == 2'd0)
            begin
                finish_char(bad_q ? REPLACEMENT : bits_q, bad_q, eot);
            end
            else if (eot)
            begin
                finish_char(REPLACEMENT, 1'b1, 1'b1);
            end
        end
        if (eot)
        begin
            clear_text();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot,
                             input bit typed = 1'b0, input out_payload_t want = UNTYPED);
        int gap;
        int depth;
        bit taken;
        gap = pacing ? idle_len() : 0;
        if (gap > 0)
        begin
            byte_stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_stream.valid   <= 1'b1;
        byte_stream.payload <= in_payload_t'{data_byte: b, end_of_text: eot};
        // ready is stable between edges; sample it ahead of the edge
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (byte_stream.ready === 1'b1);
            @(posedge clk);
        end
        depth = expected_chars.size();
        decode_byte(b, eot);
        if (typed && expected_chars.size() > depth)
        begin
            expected_chars[expected_chars.size() - 1] = want;
        end
    endtask

    task automatic drain();
        byte_stream.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_COLUMN_LIMIT)
        begin
            limit_q = value;
        end
        else if (idx == REG_BASE_OFFSET)
        begin
            base_q = value;
        end
        @(posedge clk);
    endtask

    // Mostly well-formed characters with random content, some broken or cut short
    task automatic random_phase(input int count, input bit hold_mid);
        int         sent;
        int         pick;
        int         keep;
        bit         held;
        logic [7:0] lead;
        logic [7:0] seq [$];
        sent = 0;
        held = 1'b0;
        while (sent < count)
        begin
            if (hold_mid && !held && sent >= count / 2)
            begin
                drain();
                held = 1'b1;
            end
            seq.delete();
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                seq.push_back(8'($urandom_range(0, 127)));
            end
            else if (pick < 40)
            begin
                seq.push_back(8'($urandom_range(14, 15)));
            end
            else if (pick < 55)
            begin
                seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
            else if (pick < 70)
            begin
                lead = ($urandom_range(0, 3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
                seq.push_back(lead);
                repeat (2) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
            else if (pick < 80)
            begin
                seq.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
            else if (pick < 92)
            begin
                lead = 8'($urandom_range(8'h80, 8'hFF));
                seq.push_back(lead);
                repeat (tail_of(lead)) seq.push_back(8'($urandom));
            end
            else
            begin
                seq.push_back(8'($urandom));
            end
            keep = seq.size();
            if (seq.size() > 1 && $urandom_range(0, 19) == 0)
            begin
                keep = $urandom_range(1, seq.size() - 1);
            end
            for (int i = 0; i < keep; i++)
            begin
                pacing = !(sent >= 40 && sent < 60);
                send_byte(seq[i], (i == keep - 1) &&
                          (keep < seq.size() || $urandom_range(0, 11) == 0));
                sent++;
            end
        end
        pacing = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    // valid, ready and payload are stable between edges; a transfer seen here
    // completes at the next rising edge
    always @(negedge clk)
    begin
        if (char_stream.valid === 1'b1 && char_stream.ready === 1'b1)
        begin
            if (expected_chars.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                begin
                    $error("character transfer with none expected: code_point %0h",
                           char_stream.payload.code_point);
                end
            end
            else
            begin
                oldest = expected_chars.pop_front();
                check_field("code_point", oldest.code_point, char_stream.payload.code_point);
                check_field("char_width", CP_W'(oldest.char_width),
                            CP_W'(char_stream.payload.char_width));
                check_field("start_offset", CP_W'(oldest.start_offset),
                            CP_W'(char_stream.payload.start_offset));
                check_field("columns_before", CP_W'(oldest.columns_before),
                            CP_W'(char_stream.payload.columns_before));
                check_field("columns_after", CP_W'(oldest.columns_after),
                            CP_W'(char_stream.payload.columns_after));
                check_field("fits", CP_W'(oldest.fits), CP_W'(char_stream.payload.fits));
                check_field("replaced", CP_W'(oldest.replaced),
                            CP_W'(char_stream.payload.replaced));
                check_field("text_done", CP_W'(oldest.text_done),
                            CP_W'(char_stream.payload.text_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!pacing)
        begin
            char_stream.ready <= 1'b1;
        end
        else if (ready_run == 0)
        begin
            char_stream.ready <= ($urandom_range(0, 9) < 6);
            ready_run = idle_len();
        end
        else
        begin
            ready_run = ready_run - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("utf8_column_width_measure test failed");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        byte_stream.valid   = 1'b0;
        byte_stream.payload = '0;
        char_stream.ready   = 1'b0;
        limit_q             = COLUMN_LIMIT_RESET;
        base_q              = BASE_OFFSET_RESET;
        clear_text();

        script = '{
            '{8'h41, 1'b0, 1'b1, out_payload_t'{21'h41, 2'd1, 16'd0, 16'd0, 16'd1,
                                                1'b1, 1'b0, 1'b0}},
            '{8'h00, 1'b0, 1'b1, out_payload_t'{21'h00, 2'd1, 16'd1, 16'd1, 16'd2,
                                                1'b1, 1'b0, 1'b0}},
            '{8'h7F, 1'b0, 1'b1, out_payload_t'{21'h7F, 2'd0, 16'd2, 16'd2, 16'd2,
                                                1'b1, 1'b0, 1'b0}},
            '{8'h0E, 1'b0, 1'b1, out_payload_t'{21'h0E, 2'd0, 16'd3, 16'd2, 16'd2,
                                                1'b1, 1'b0, 1'b0}},
            '{8'hC3, 1'b0, 1'b0, UNTYPED},
            '{8'hA9, 1'b0, 1'b0, UNTYPED},
            '{8'hE4, 1'b0, 1'b0, UNTYPED},
            '{8'hB8, 1'b0, 1'b0, UNTYPED},
            '{8'h80, 1'b0, 1'b0, UNTYPED},
            // surrogate half
            '{8'hED, 1'b0, 1'b0, UNTYPED},
            '{8'hA0, 1'b0, 1'b0, UNTYPED},
            '{8'h80, 1'b0, 1'b0, UNTYPED},
            // bad continuation
            '{8'hC3, 1'b0, 1'b0, UNTYPED},
            '{8'h41, 1'b0, 1'b0, UNTYPED},
            // invalid lead, four bytes
            '{8'hFF, 1'b0, 1'b0, UNTYPED},
            '{8'h80, 1'b0, 1'b0, UNTYPED},
            '{8'h80, 1'b0, 1'b0, UNTYPED},
            '{8'h80, 1'b0, 1'b0, UNTYPED},
            // largest four-byte value, no range check
            '{8'hF7, 1'b0, 1'b0, UNTYPED},
            '{8'hBF, 1'b0, 1'b0, UNTYPED},
            '{8'hBF, 1'b0, 1'b0, UNTYPED},
            '{8'hBF, 1'b0, 1'b0, UNTYPED},
            // cut short by end of text
            '{8'hE4, 1'b0, 1'b0, UNTYPED},
            '{8'hB8, 1'b1, 1'b0, UNTYPED}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            send_byte(script[i].data_byte, script[i].end_of_text, script[i].typed,
                      script[i].want);
        end
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_COLUMN_LIMIT, 16'h0000);
                    write_reg(REG_BASE_OFFSET, 16'hFFFF);
                    write_reg(REG_SPARE_A, 16'($urandom));
                end
                1:
                begin
                    write_reg(REG_COLUMN_LIMIT, 16'($urandom_range(1, 30)));
                    write_reg(REG_BASE_OFFSET, 16'($urandom_range(65500, 65535)));
                end
                2:
                begin
                    write_reg(REG_COLUMN_LIMIT, 16'($urandom));
                    write_reg(REG_BASE_OFFSET, 16'($urandom));
                end
                3:
                begin
                    write_reg(REG_COLUMN_LIMIT, 16'hFFFF);
                    write_reg(REG_BASE_OFFSET, 16'h0000);
                    write_reg(REG_SPARE_B, 16'($urandom));
                end
                4:
                begin
                    write_reg(REG_COLUMN_LIMIT, 16'($urandom_range(0, 12)));
                    write_reg(REG_BASE_OFFSET, 16'($urandom));
                end
                default:
                begin
                    write_reg(REG_COLUMN_LIMIT, 16'($urandom));
                    write_reg(REG_BASE_OFFSET, 16'($urandom_range(0, 100)));
                end
            endcase
            random_phase(PHASE_ITEMS, p == 2);
            drain();
        end

        if (fail_count == 0)
        begin
            $display("utf8_column_width_measure test passed");
        end
        else
        begin
            $display("utf8_column_width_measure test failed");
        end
        $finish;
    end

endmodule
